/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication checked every clock, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked every clock, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/dcm_pkg.sv */
// ----------------------------------------------------------------------------
// Command mailbox package
// Widths, codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam int unsigned Clients     = 8;
  localparam int unsigned ClientBits  = 3;
  localparam int unsigned Depth       = 4;
  localparam int unsigned SlotBits    = 2;
  localparam int unsigned OrderBits   = 16;
  localparam int unsigned EntryWidth  = 32 + 32 + 64 + OrderBits;
  localparam int unsigned MemDepth    = Clients * Depth;
  localparam int unsigned MemAddrBits = ClientBits + SlotBits;
  localparam int unsigned FrontWidth  = 32 + 32 + 64;

  typedef enum logic [2:0] {
    CMD_PUBLISH = 3'd0,
    CMD_PEEK    = 3'd1,
    CMD_CONSUME = 3'd2,
    CMD_TAKE    = 3'd3,
    CMD_RESET   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    F_NONE     = 3'd0,
    F_INVALID  = 3'd1,
    F_EPOCH    = 3'd2,
    F_REGRESS  = 3'd3,
    F_CONFLICT = 3'd4,
    F_FULL     = 3'd5,
    F_EXHAUST  = 3'd6
  } fail_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  client;
    logic [31:0] epoch;
    logic [31:0] sequence_req;
    logic [63:0] payload;
    logic        receipt_valid;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_epoch;
    logic [31:0] out_sequence;
    logic [63:0] out_payload;
    logic [2:0]  failure_code;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic                load;      // capture the input transaction
    logic                rd_en;     // issue a slot read
    logic [SlotBits-1:0] rd_slot;
    logic                scan;      // absorb the slot read data
    logic                decide;    // evaluate and commit the operation
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic rsp_ready;
  } sts_t;

endpackage

/* hw/rtl/dcm_stream_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one transaction of a packed payload type.
// ----------------------------------------------------------------------------
interface dcm_req_if;
  logic          valid;
  logic          ready;
  dcm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcm_rsp_if;
  logic          valid;
  logic          ready;
  dcm_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dcm_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write and one registered read per cycle, through separate write and read ports.
// ----------------------------------------------------------------------------
module dcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* hw/rtl/dcm_ctrl.sv */
// ----------------------------------------------------------------------------
// Mailbox controller
// Sequences slot reads, the decision step and the response handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dcm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dcm_pkg::sts_t  sts_i,
  output dcm_pkg::ctl_t  ctl_o
);
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_WAIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [dcm_pkg::SlotBits:0] cnt_q, cnt_d;

  // Next state and command generation.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctl_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !sts_i.rsp_ready;
        if (in_valid_i && !sts_i.rsp_ready) begin
          ctl_o.load = 1'b1;
          ctl_o.rd_en = 1'b1;
          ctl_o.rd_slot = '0;
          cnt_d = (dcm_pkg::SlotBits+1)'(1);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // Data from the previous read arrives; issue the next read until all slots are read.
        ctl_o.scan = 1'b1;
        ctl_o.rd_slot = cnt_q[dcm_pkg::SlotBits-1:0];
        if (cnt_q == (dcm_pkg::SlotBits+1)'(dcm_pkg::Depth)) begin
          state_d = ST_DECIDE;
        end else begin
          ctl_o.rd_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        ctl_o.decide = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (!sts_i.rsp_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_IMPL(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `ASSERT_NEXT(a_decide_wait, clk_i, rst_ni, ctl_o.decide, state_q == ST_WAIT)
  `ASSERT_IMPL(a_load_idle, clk_i, rst_ni, ctl_o.load, state_q == ST_IDLE)
endmodule

/* hw/rtl/dcm_dpath.sv */
// ----------------------------------------------------------------------------
// Mailbox datapath
// Per-client control state, slot RAM, scan results and the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dcm_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dcm_pkg::req_t req_i,
  input  dcm_pkg::ctl_t ctl_i,
  output dcm_pkg::sts_t sts_o,
  output dcm_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i
);
  localparam int unsigned CB = dcm_pkg::ClientBits;
  localparam int unsigned SB = dcm_pkg::SlotBits;
  localparam int unsigned OB = dcm_pkg::OrderBits;

  dcm_pkg::req_t req_q;
  logic [dcm_pkg::Depth-1:0] used_q [dcm_pkg::Clients];
  logic [dcm_pkg::Clients-1:0] known_q, blocked_q;
  logic [2:0] pend_q [dcm_pkg::Clients];
  logic [dcm_pkg::FrontWidth-1:0] front_q [dcm_pkg::Clients];
  logic [OB-1:0] order_q;

  // Scan results.
  logic [SB-1:0] sidx_q;
  logic          match_q, mism_q, hasfree_q, hasold_q;
  logic [SB-1:0] free_q, old_q;
  logic [OB-1:0] oldord_q;
  logic [127:0]  olddat_q;

  logic rsp_valid_q;
  dcm_pkg::rsp_t rsp_q;

  // Slot RAM.
  logic we;
  logic [dcm_pkg::MemAddrBits-1:0] waddr, raddr;
  logic [dcm_pkg::EntryWidth-1:0] wdata, rdata;

  assign raddr = {req_i.client, ctl_i.rd_slot};

  dcm_ram #(.Width(dcm_pkg::EntryWidth), .Depth(dcm_pkg::MemDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctl_i.rd_en),
    .raddr_i(ctl_i.load ? raddr : {req_q.client, ctl_i.rd_slot}),
    .rdata_o(rdata)
  );

  logic [31:0] r_ep, r_sq;
  logic [63:0] r_pl;
  logic [OB-1:0] r_or;
  logic r_used;
  assign {r_ep, r_sq, r_pl, r_or} = rdata;
  assign r_used = used_q[req_q.client][sidx_q];

  // Scan of one slot per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
      sidx_q <= '0;
      match_q <= 1'b0;
      mism_q <= 1'b0;
      hasfree_q <= 1'b0;
      hasold_q <= 1'b0;
    end else if (ctl_i.scan) begin
      sidx_q <= sidx_q + 1'b1;
      if (!r_used) begin
        if (!hasfree_q) begin
          hasfree_q <= 1'b1;
          free_q <= sidx_q;
        end
      end else begin
        if (!match_q && !mism_q && r_ep == req_q.epoch && r_sq == req_q.sequence_req) begin
          if (r_pl == req_q.payload) match_q <= 1'b1;
          else mism_q <= 1'b1;
        end
        if (!hasold_q || r_or < oldord_q) begin
          hasold_q <= 1'b1;
          old_q <= sidx_q;
          oldord_q <= r_or;
          olddat_q <= {r_ep, r_sq, r_pl};
        end
      end
    end
  end

  // Decision for the captured transaction.
  logic [CB-1:0] c;
  logic [31:0] f_ep, f_sq;
  logic [63:0] f_pl;
  logic err;
  logic [2:0] ecode;
  logic pub_ok, store;
  dcm_pkg::rsp_t rsp_d;
  assign c = req_q.client;
  assign {f_ep, f_sq, f_pl} = front_q[c];

  always_comb begin
    err = 1'b0;
    ecode = dcm_pkg::F_NONE;
    pub_ok = 1'b0;
    store = 1'b0;
    rsp_d = '0;
    unique case (dcm_pkg::cmd_e'(req_q.command))
      dcm_pkg::CMD_PUBLISH: begin
        if (blocked_q[c]) begin
          pub_ok = 1'b0;
        end else if (!req_q.receipt_valid) begin
          err = 1'b1; ecode = dcm_pkg::F_INVALID;
        end else if (known_q[c] && req_q.epoch != f_ep) begin
          err = 1'b1; ecode = dcm_pkg::F_EPOCH;
        end else if (known_q[c] && req_q.sequence_req < f_sq) begin
          err = 1'b1; ecode = dcm_pkg::F_REGRESS;
        end else if (known_q[c] && req_q.sequence_req == f_sq) begin
          if (req_q.payload == f_pl) pub_ok = 1'b1;
          else begin err = 1'b1; ecode = dcm_pkg::F_CONFLICT; end
        end else if (match_q) begin
          pub_ok = 1'b1;
        end else if (mism_q) begin
          err = 1'b1; ecode = dcm_pkg::F_CONFLICT;
        end else if (!hasfree_q) begin
          err = 1'b1; ecode = dcm_pkg::F_FULL;
        end else if (order_q == '1) begin
          err = 1'b1; ecode = dcm_pkg::F_EXHAUST;
        end else begin
          pub_ok = 1'b1; store = 1'b1;
        end
        rsp_d.ok = pub_ok;
      end
      dcm_pkg::CMD_PEEK: begin
        if (hasold_q) begin
          rsp_d.ok = 1'b1;
          {rsp_d.out_epoch, rsp_d.out_sequence, rsp_d.out_payload} = olddat_q;
        end
      end
      dcm_pkg::CMD_CONSUME: begin
        rsp_d.ok = req_q.receipt_valid && hasold_q &&
                   olddat_q == {req_q.epoch, req_q.sequence_req, req_q.payload};
      end
      dcm_pkg::CMD_TAKE: begin
        if (pend_q[c] != dcm_pkg::F_NONE) begin
          rsp_d.ok = 1'b1;
          rsp_d.failure_code = pend_q[c];
        end
      end
      dcm_pkg::CMD_RESET: rsp_d.ok = 1'b1;
      default: rsp_d = '0;
    endcase
  end

  assign we = ctl_i.decide && store;
  assign waddr = {c, free_q};
  assign wdata = {req_q.epoch, req_q.sequence_req, req_q.payload, order_q + 1'b1};

  // Front values need no reset.
  always_ff @(posedge clk_i) begin
    if (we) front_q[c] <= {req_q.epoch, req_q.sequence_req, req_q.payload};
  end

  // Per-client control state and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dcm_pkg::Clients; i++) begin
        used_q[i] <= '0;
        pend_q[i] <= dcm_pkg::F_NONE;
      end
      known_q <= '0;
      blocked_q <= '0;
      order_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      if (ctl_i.decide) begin
        rsp_valid_q <= 1'b1;
        if (err) begin
          blocked_q[c] <= 1'b1;
          if (pend_q[c] == dcm_pkg::F_NONE) pend_q[c] <= ecode;
        end
        if (store) begin
          order_q <= order_q + 1'b1;
          used_q[c][free_q] <= 1'b1;
          known_q[c] <= 1'b1;
        end
        if (req_q.command == dcm_pkg::CMD_CONSUME && rsp_d.ok) used_q[c][old_q] <= 1'b0;
        if (req_q.command == dcm_pkg::CMD_TAKE) pend_q[c] <= dcm_pkg::F_NONE;
        if (req_q.command == dcm_pkg::CMD_RESET) begin
          used_q[c] <= '0;
          known_q[c] <= 1'b0;
          blocked_q[c] <= 1'b0;
          pend_q[c] <= dcm_pkg::F_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.decide) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_valid_q;
  assign sts_o.rsp_ready = rsp_valid_q;

  `ASSERT_IMPL(a_err_not_ok, clk_i, rst_ni, ctl_i.decide && err, !rsp_d.ok)
  `ASSERT_IMPL(a_store_free, clk_i, rst_ni, we, !used_q[c][free_q])
  `ASSERT_NEXT(a_order_step, clk_i, rst_ni, we, order_q == $past(order_q) + 1'b1)
endmodule

/* hw/rtl/dedup_command_mailbox_top.sv */
// Command mailbox with duplicate suppression, eight clients of four slots.
// Channel req_if carries one command transaction: command, client, epoch,
// sequence_req, payload and receipt_valid. Channel rsp_if returns exactly
// one result transaction per command: ok, out_epoch, out_sequence,
// out_payload and failure_code.
// After acceptance, with the slot 0 read issued at the accepting edge, the
// READ state scans the client's slots through the single read port of the
// slot RAM, and the DECIDE state decides, commits and registers the result.
// A new command is accepted only after the previous result has been taken
// and the controller has returned to idle, so commands never overlap.
// While the receiver holds ready low the result register holds its value
// and no new command is accepted.
// Reset clears all slot-used, frontier-known, blocked and failure state,
// the order counter and both handshakes; it needs no clearing pass.
// ----------------------------------------------------------------------------
// Command mailbox top level
// Joins the controller and the datapath to the two stream channels.
// ----------------------------------------------------------------------------
module dedup_command_mailbox_top (
  input  logic clk_i,
  input  logic rst_ni,
  dcm_req_if.sink   req_if,
  dcm_rsp_if.source rsp_if
);
  dcm_pkg::ctl_t ctl;
  dcm_pkg::sts_t sts;

  dcm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_if.valid),
    .in_ready_o(req_if.ready),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  dcm_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.data),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .rsp_o      (rsp_if.data),
    .rsp_valid_o(rsp_if.valid),
    .rsp_ready_i(rsp_if.ready)
  );
endmodule

/* tb/tb_dedup_command_mailbox_top.sv */
// ----------------------------------------------------------------------------
// Command mailbox testbench
// Drives command transactions through the request channel and compares each
// result with its typed-in row result, else a behavioural mailbox predictor.
// ----------------------------------------------------------------------------
module tb_dedup_command_mailbox_top;
  import dcm_pkg::*;

  logic clk_i;
  logic rst_ni;

  dcm_req_if req_if ();
  dcm_rsp_if rsp_if ();

  dedup_command_mailbox_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if.sink),
    .rsp_if (rsp_if.source)
  );

  // Clock with a 12 unit period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: per-client slots, frontier and failure state, plus the order counter.
  logic        mb_used  [Clients][Depth];
  logic [31:0] mb_epoch [Clients][Depth];
  logic [31:0] mb_seq   [Clients][Depth];
  logic [63:0] mb_pay   [Clients][Depth];
  logic [15:0] mb_order [Clients][Depth];
  logic        fr_known [Clients];
  logic [31:0] fr_epoch [Clients];
  logic [31:0] fr_seq   [Clients];
  logic [63:0] fr_pay   [Clients];
  fail_e       latched  [Clients];
  logic        blk      [Clients];
  logic [15:0] order_cnt;

  rsp_t  expected_q[$];
  int    mismatches;
  int    cycles;
  bit    hold_off;
  bit    stim_done;

  // Directed stimulus rows; has_exp marks rows whose result is typed in.
  typedef struct {
    req_t req;
    bit   has_exp;
    rsp_t exp;
  } row_t;

  function automatic void clear_client(int c);
    for (int i = 0; i < Depth; i++) mb_used[c][i] = 1'b0;
    fr_known[c] = 1'b0;
    latched[c]  = F_NONE;
    blk[c]      = 1'b0;
  endfunction

  function automatic void latch_fail(int c, fail_e code);
    if (latched[c] == F_NONE) latched[c] = code;
    blk[c] = 1'b1;
  endfunction

  function automatic int oldest_slot(int c);
    int sel;
    sel = -1;
    for (int i = 0; i < Depth; i++)
      if (mb_used[c][i] && (sel < 0 || mb_order[c][i] < mb_order[c][sel])) sel = i;
    return sel;
  endfunction

  function automatic logic publish(int c, req_t r);
    int fs;
    fs = -1;
    if (blk[c]) return 1'b0;
    if (!r.receipt_valid) begin
      latch_fail(c, F_INVALID);
      return 1'b0;
    end
    if (fr_known[c]) begin
      if (r.epoch != fr_epoch[c]) begin
        latch_fail(c, F_EPOCH);
        return 1'b0;
      end
      if (r.sequence_req < fr_seq[c]) begin
        latch_fail(c, F_REGRESS);
        return 1'b0;
      end
      if (r.sequence_req == fr_seq[c]) begin
        if (r.payload == fr_pay[c]) return 1'b1;
        latch_fail(c, F_CONFLICT);
        return 1'b0;
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (!mb_used[c][i]) begin
        if (fs < 0) fs = i;
      end else if (mb_epoch[c][i] == r.epoch && mb_seq[c][i] == r.sequence_req) begin
        if (mb_pay[c][i] == r.payload) return 1'b1;
        latch_fail(c, F_CONFLICT);
        return 1'b0;
      end
    end
    if (fs < 0) begin
      latch_fail(c, F_FULL);
      return 1'b0;
    end
    if (order_cnt == 16'hFFFF) begin
      latch_fail(c, F_EXHAUST);
      return 1'b0;
    end
    order_cnt       = order_cnt + 16'd1;
    mb_used[c][fs]  = 1'b1;
    mb_epoch[c][fs] = r.epoch;
    mb_seq[c][fs]   = r.sequence_req;
    mb_pay[c][fs]   = r.payload;
    mb_order[c][fs] = order_cnt;
    fr_known[c]     = 1'b1;
    fr_epoch[c]     = r.epoch;
    fr_seq[c]       = r.sequence_req;
    fr_pay[c]       = r.payload;
    return 1'b1;
  endfunction

  // Works out the result of one command and updates the predictor state.
  function automatic rsp_t predict_mailbox(req_t r);
    rsp_t o;
    int   c;
    int   s;
    o = '0;
    c = r.client;
    case (r.command)
      CMD_PUBLISH: o.ok = publish(c, r);
      CMD_PEEK: begin
        s = oldest_slot(c);
        if (s >= 0) begin
          o.ok           = 1'b1;
          o.out_epoch    = mb_epoch[c][s];
          o.out_sequence = mb_seq[c][s];
          o.out_payload  = mb_pay[c][s];
        end
      end
      CMD_CONSUME: begin
        s = oldest_slot(c);
        if (r.receipt_valid && s >= 0 && mb_epoch[c][s] == r.epoch &&
            mb_seq[c][s] == r.sequence_req && mb_pay[c][s] == r.payload) begin
          mb_used[c][s] = 1'b0;
          o.ok = 1'b1;
        end
      end
      CMD_TAKE: begin
        if (latched[c] != F_NONE) begin
          o.ok           = 1'b1;
          o.failure_code = latched[c];
          latched[c]     = F_NONE;
        end
      end
      CMD_RESET: begin
        clear_client(c);
        o.ok = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Sends one transaction and records its expected result.
  task automatic send_cmd(req_t r, bit has_exp, rsp_t exp);
    rsp_t p;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = predict_mailbox(r);
    if (has_exp && p !== exp)
      $display("%0t: directed row disagrees with predictor exp=%h pred=%h", $time, exp, p);
    expected_q.push_back(has_exp ? exp : p);
  endtask

  task automatic idle_gap(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic req_t mk(cmd_e cmd, int c, logic [31:0] ep, logic [31:0] sq,
                              logic [63:0] pl, logic v);
    req_t r;
    r.command = cmd; r.client = c[2:0]; r.epoch = ep; r.sequence_req = sq;
    r.payload = pl; r.receipt_valid = v;
    return r;
  endfunction

  function automatic rsp_t okr(logic ok, logic [2:0] code);
    rsp_t o;
    o = '0; o.ok = ok; o.failure_code = code;
    return o;
  endfunction

  // Random transaction, mostly well-formed traffic around the client frontier.
  function automatic req_t rand_cmd();
    req_t r;
    int   c;
    int   k;
    c = $urandom_range(0, 7);
    r = mk(CMD_PUBLISH, c, fr_known[c] ? fr_epoch[c] : $urandom_range(0, 3),
           fr_known[c] ? fr_seq[c] + $urandom_range(0, 3) : $urandom(),
           {60'h0, 4'($urandom_range(0, 3))}, $urandom_range(0, 19) != 0);
    k = $urandom_range(0, 99);
    if (k < 40) begin
      if ($urandom_range(0, 9) == 0) r.epoch = $urandom();
      if ($urandom_range(0, 9) == 0) r.sequence_req = $urandom();
      if ($urandom_range(0, 9) == 0) r.payload = {$urandom(), $urandom()};
    end else if (k < 55) r.command = CMD_PEEK;
    else if (k < 75) begin
      r.command = CMD_CONSUME;
      if (oldest_slot(c) >= 0 && $urandom_range(0, 4) != 0) begin
        r.epoch        = mb_epoch[c][oldest_slot(c)];
        r.sequence_req = mb_seq[c][oldest_slot(c)];
        r.payload      = mb_pay[c][oldest_slot(c)];
      end
    end else if (k < 85) r.command = CMD_TAKE;
    else if (k < 95) r.command = CMD_RESET;
    else begin
      r.command = cmd_e'($urandom_range(0, 7));
      r.epoch = $urandom(); r.sequence_req = $urandom();
      r.payload = {$urandom(), $urandom()};
      r.receipt_valid = $urandom_range(0, 1);
    end
    return r;
  endfunction

  // Stimulus: reset, directed table, then random bursts.
  initial begin
    row_t rows[$];
    int   burst;
    bit   held;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    hold_off     = 1'b0;
    stim_done    = 1'b0;
    held         = 1'b0;
    mismatches   = 0;
    order_cnt    = '0;
    for (int c = 0; c < Clients; c++) clear_client(c);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{mk(CMD_PEEK, 0, 0, 0, 0, 1), 1, okr(0, F_NONE)});
    rows.push_back('{mk(CMD_TAKE, 0, 0, 0, 0, 1), 1, okr(0, F_NONE)});
    rows.push_back('{mk(CMD_CONSUME, 0, 0, 0, 0, 1), 1, okr(0, F_NONE)});
    rows.push_back('{mk(CMD_PUBLISH, 0, 32'hFFFFFFFF, 32'hFFFFFFFE, '1, 1), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 0, 32'hFFFFFFFF, 32'hFFFFFFFE, '1, 1), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PEEK, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_CONSUME, 0, 32'hFFFFFFFF, 32'hFFFFFFFE, '1, 0), 1, okr(0, 0)});
    rows.push_back('{mk(CMD_CONSUME, 0, 32'hFFFFFFFF, 32'hFFFFFFFE, '1, 1), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1), 1, okr(0, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 0, 32'hFFFFFFFF, 32'h5, 0, 1), 1, okr(0, 0)});
    rows.push_back('{mk(CMD_TAKE, 0, 0, 0, 0, 1), 1, okr(1, F_CONFLICT)});
    rows.push_back('{mk(CMD_TAKE, 0, 0, 0, 0, 1), 1, okr(0, F_NONE)});
    rows.push_back('{mk(CMD_RESET, 0, 0, 0, 0, 0), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 1, 0, 0, 0, 0), 1, okr(0, 0)});
    rows.push_back('{mk(CMD_TAKE, 1, 0, 0, 0, 0), 1, okr(1, F_INVALID)});
    rows.push_back('{mk(CMD_PUBLISH, 2, 5, 9, 7, 1), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 2, 6, 9, 7, 1), 1, okr(0, 0)});
    rows.push_back('{mk(CMD_TAKE, 2, 0, 0, 0, 1), 1, okr(1, F_EPOCH)});
    rows.push_back('{mk(CMD_PUBLISH, 3, 0, 9, 0, 1), 1, okr(1, 0)});
    rows.push_back('{mk(CMD_PUBLISH, 3, 0, 8, 0, 1), 1, okr(0, 0)});
    rows.push_back('{mk(CMD_TAKE, 3, 0, 0, 0, 1), 1, okr(1, F_REGRESS)});
    for (int i = 0; i < 5; i++)
      rows.push_back('{mk(CMD_PUBLISH, 7, 0, i, 0, 1), 0, '0});
    rows.push_back('{mk(CMD_TAKE, 7, 0, 0, 0, 1), 1, okr(1, F_FULL)});
    rows.push_back('{mk(cmd_e'(3'd7), 7, 0, 0, 0, 1), 1, okr(0, 0)});
    foreach (rows[i]) send_cmd(rows[i].req, rows[i].has_exp, rows[i].exp);
    idle_gap(1);

    // Random part, with one long receiver hold-off early on.
    for (int n = 0; n < 850; ) begin
      burst = $urandom_range(1, 12);
      if (n >= 100 && !held) begin
        hold_off = 1'b1;
        held     = 1'b1;
      end
      for (int b = 0; b < burst; b++) begin
        send_cmd(rand_cmd(), 0, '0);
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 20));
    end
    req_if.valid <= 1'b0;
    stim_done    <= 1'b1;
  end

  // Receiver: random stall pattern plus one long hold-off.
  initial begin
    int pat;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      pat = $urandom_range(0, 15);
      rsp_if.ready <= (pat < 4) ? 1'b0 : ((pat < 10) ? 1'b1 : rsp_if.ready);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp_if.data);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        if (rsp_if.data.ok !== e.ok) begin
          $display("%0t: ok exp=%0h act=%0h", $time, e.ok, rsp_if.data.ok);
          mismatches++;
        end
        if (rsp_if.data.out_epoch !== e.out_epoch) begin
          $display("%0t: out_epoch exp=%h act=%h", $time, e.out_epoch,
                   rsp_if.data.out_epoch);
          mismatches++;
        end
        if (rsp_if.data.out_sequence !== e.out_sequence) begin
          $display("%0t: out_sequence exp=%h act=%h", $time, e.out_sequence,
                   rsp_if.data.out_sequence);
          mismatches++;
        end
        if (rsp_if.data.out_payload !== e.out_payload) begin
          $display("%0t: out_payload exp=%h act=%h", $time, e.out_payload,
                   rsp_if.data.out_payload);
          mismatches++;
        end
        if (rsp_if.data.failure_code !== e.failure_code) begin
          $display("%0t: failure_code exp=%0d act=%0d", $time, e.failure_code,
                   rsp_if.data.failure_code);
          mismatches++;
        end
      end
    end
  end

  // End of run: drain, settle, report; or stop at the cycle limit.
  initial begin
    cycles = 0;
    fork
      begin
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge clk_i);
        repeat (20) @(posedge clk_i);
        if (mismatches == 0 && expected_q.size() == 0)
          $display("end of test: clean");
        else
          $display("end of test: mismatches");
      end
      begin
        while (cycles < 400000) begin
          @(posedge clk_i);
          cycles++;
        end
        $display("%0t: cycle limit reached", $time);
        $display("end of test: mismatches");
      end
    join_any
    $finish;
  end

endmodule
